// ===== hdl/nir_pkg.sv =====
// Shared types, constants and ring index helpers for the NEC IR edge decoder.
`default_nettype none

package nir_pkg;

  localparam int RING_DEPTH = 128;
  localparam int IDX_W      = $clog2(RING_DEPTH);
  localparam int DUR_W      = 16;
  localparam int LIMIT_W    = 20;

  localparam logic [LIMIT_W-1:0] IDLE_GAP_RESET = LIMIT_W'(50000);

  // action codes
  localparam logic [1:0] ACT_EDGE   = 2'd0;
  localparam logic [1:0] ACT_DECODE = 2'd1;
  localparam logic [1:0] ACT_RESUME = 2'd2;
  localparam logic [1:0] ACT_ARM    = 2'd3;

  // NEC timing windows in microseconds
  localparam logic [DUR_W-1:0] HDR_MARK_MIN  = 16'd4000;
  localparam logic [DUR_W-1:0] HDR_MARK_MAX  = 16'd14000;
  localparam logic [DUR_W-1:0] HDR_SPACE_MIN = 16'd1400;
  localparam logic [DUR_W-1:0] HDR_SPACE_MAX = 16'd5200;
  localparam logic [DUR_W-1:0] HDR_SPACE_DATA = 16'd3000;
  localparam logic [DUR_W-1:0] BIT_MARK_MIN  = 16'd200;
  localparam logic [DUR_W-1:0] BIT_MARK_MAX  = 16'd1000;
  localparam logic [DUR_W-1:0] BIT_SPACE_MIN = 16'd300;
  localparam logic [DUR_W-1:0] BIT_SPACE_MAX = 16'd2500;
  localparam logic [DUR_W-1:0] BIT_ONE_SPACE = 16'd1100;
  localparam logic [DUR_W-1:0] DUR_SAT       = 16'hFFFF;

  localparam logic [IDX_W-1:0] HDR_MIN_AVAIL  = IDX_W'(3);
  localparam logic [IDX_W-1:0] REPEAT_LEN     = IDX_W'(3);
  localparam logic [IDX_W-1:0] DATA_FRAME_LEN = IDX_W'(66);

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] edge_time_us;
  } in_item_t;

  typedef struct packed {
    logic        frame_found;
    logic        is_repeat;
    logic [31:0] code_value;
    logic [7:0]  pending_count;
  } out_item_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [DUR_W-1:0] wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

  function automatic logic [IDX_W-1:0] idx_add(input logic [IDX_W-1:0] idx,
                                               input logic [IDX_W-1:0] step);
    logic [IDX_W:0] sum;
    sum = {1'b0, idx} + {1'b0, step};
    if (sum >= (IDX_W+1)'(RING_DEPTH)) begin
      sum = sum - (IDX_W+1)'(RING_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
    return idx_add(idx, IDX_W'(1));
  endfunction

  function automatic logic [IDX_W-1:0] ring_pending(input logic [IDX_W-1:0] wr,
                                                    input logic [IDX_W-1:0] rd);
    logic [IDX_W:0] diff;
    if (wr >= rd) begin
      diff = {1'b0, wr} - {1'b0, rd};
    end else begin
      diff = ({1'b0, wr} + (IDX_W+1)'(RING_DEPTH)) - {1'b0, rd};
    end
    return diff[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/nir_ring_ram.sv =====
// Single-port-write, single-port-read synchronous RAM with registered read data.
`default_nettype none

module nir_ring_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hdl/nir_ctrl.sv =====
// Sequencer: ring indices, edge timing and the NEC frame walk over the ring RAM.
`default_nettype none

module nir_ctrl
  import nir_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire in_item_t           in_data,
  input  wire logic [LIMIT_W-1:0] idle_gap_limit,
  output logic                    res_valid,
  input  wire logic               res_ready,
  output out_item_t               res_data,
  output ram_req_t                ram_req,
  input  wire logic [DUR_W-1:0]   ram_rdata
);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_EXEC  = 8'b0000_0010,
    ST_EDGE  = 8'b0000_0100,
    ST_HDR_M = 8'b0000_1000,
    ST_HDR_S = 8'b0001_0000,
    ST_BIT_M = 8'b0010_0000,
    ST_BIT_S = 8'b0100_0000,
    ST_FIN   = 8'b1000_0000
  } state_t;

  state_t           st_r, st_nxt;
  logic [1:0]       act_r;
  logic [31:0]      time_r;
  logic [31:0]      gap_r, gap_nxt;
  logic [31:0]      last_r, last_nxt;
  logic [IDX_W-1:0] wr_r, wr_nxt;
  logic [IDX_W-1:0] rd_r, rd_nxt;
  logic [IDX_W-1:0] rptr_r, rptr_nxt;
  logic [4:0]       bit_r, bit_nxt;
  logic             hm_ok_r, hm_ok_nxt;
  logic             m_ok_r, m_ok_nxt;
  logic [31:0]      code_r, code_nxt;
  logic             found_r, found_nxt;
  logic             rep_r, rep_nxt;

  logic [IDX_W-1:0] avail;
  logic [IDX_W-1:0] wr_inc;
  logic             hs_ok;
  logic             s_ok;

  assign avail  = ring_pending(wr_r, rd_r);
  assign wr_inc = idx_inc(wr_r);
  assign hs_ok  = (ram_rdata >= HDR_SPACE_MIN) && (ram_rdata <= HDR_SPACE_MAX);
  assign s_ok   = (ram_rdata >= BIT_SPACE_MIN) && (ram_rdata <= BIT_SPACE_MAX);

  assign in_ready  = (st_r == ST_IDLE);
  assign res_valid = (st_r == ST_FIN);

  always_comb begin
    res_data.frame_found   = found_r;
    res_data.is_repeat     = rep_r;
    res_data.code_value    = code_r;
    res_data.pending_count = 8'(avail);
  end

  always_comb begin
    st_nxt    = st_r;
    gap_nxt   = gap_r;
    last_nxt  = last_r;
    wr_nxt    = wr_r;
    rd_nxt    = rd_r;
    rptr_nxt  = rptr_r;
    bit_nxt   = bit_r;
    hm_ok_nxt = hm_ok_r;
    m_ok_nxt  = m_ok_r;
    code_nxt  = code_r;
    found_nxt = found_r;
    rep_nxt   = rep_r;
    ram_req   = '0;

    case (st_r)
      ST_IDLE: begin
        if (in_valid) begin
          st_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        found_nxt = 1'b0;
        rep_nxt   = 1'b0;
        code_nxt  = '0;
        st_nxt    = ST_FIN;
        case (act_r)
          ACT_EDGE: begin
            gap_nxt = time_r - last_r;
            st_nxt  = ST_EDGE;
          end
          ACT_DECODE: begin
            if (avail >= HDR_MIN_AVAIL) begin
              ram_req.re    = 1'b1;
              ram_req.raddr = rd_r;
              rptr_nxt      = idx_inc(rd_r);
              st_nxt        = ST_HDR_M;
            end
          end
          ACT_RESUME: begin
            rd_nxt = wr_r;
          end
          ACT_ARM: begin
            wr_nxt   = '0;
            rd_nxt   = '0;
            last_nxt = time_r;
          end
          default: begin
            st_nxt = ST_FIN;
          end
        endcase
      end
      ST_EDGE: begin
        // gap already registered; store it unless it is inter-frame idle
        last_nxt = time_r;
        if (gap_r <= {12'd0, idle_gap_limit}) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = wr_r;
          ram_req.wdata = (gap_r > {16'd0, DUR_SAT}) ? DUR_SAT : gap_r[DUR_W-1:0];
          wr_nxt        = wr_inc;
          if (wr_inc == rd_r) begin
            rd_nxt = idx_inc(rd_r);
          end
        end
        st_nxt = ST_FIN;
      end
      ST_HDR_M: begin
        hm_ok_nxt     = (ram_rdata >= HDR_MARK_MIN) && (ram_rdata <= HDR_MARK_MAX);
        ram_req.re    = 1'b1;
        ram_req.raddr = rptr_r;
        rptr_nxt      = idx_inc(rptr_r);
        st_nxt        = ST_HDR_S;
      end
      ST_HDR_S: begin
        st_nxt = ST_FIN;
        if (!hm_ok_r || !hs_ok) begin
          rd_nxt = idx_inc(rd_r);
        end else if (ram_rdata > HDR_SPACE_DATA) begin
          if (avail >= DATA_FRAME_LEN) begin
            ram_req.re    = 1'b1;
            ram_req.raddr = rptr_r;
            rptr_nxt      = idx_inc(rptr_r);
            bit_nxt       = '0;
            st_nxt        = ST_BIT_M;
          end
        end else begin
          // repeat frame: header mark, short space, trailing mark
          rd_nxt    = idx_add(rd_r, REPEAT_LEN);
          found_nxt = 1'b1;
          rep_nxt   = 1'b1;
        end
      end
      ST_BIT_M: begin
        m_ok_nxt      = (ram_rdata >= BIT_MARK_MIN) && (ram_rdata <= BIT_MARK_MAX);
        ram_req.re    = 1'b1;
        ram_req.raddr = rptr_r;
        rptr_nxt      = idx_inc(rptr_r);
        st_nxt        = ST_BIT_S;
      end
      ST_BIT_S: begin
        if (!m_ok_r || !s_ok) begin
          rd_nxt   = idx_inc(rd_r);
          code_nxt = '0;
          st_nxt   = ST_FIN;
        end else begin
          if (ram_rdata > BIT_ONE_SPACE) begin
            code_nxt[bit_r] = 1'b1;
          end
          if (bit_r == 5'd31) begin
            rd_nxt    = idx_add(rd_r, DATA_FRAME_LEN);
            found_nxt = 1'b1;
            st_nxt    = ST_FIN;
          end else begin
            ram_req.re    = 1'b1;
            ram_req.raddr = rptr_r;
            rptr_nxt      = idx_inc(rptr_r);
            bit_nxt       = bit_r + 5'd1;
            st_nxt        = ST_BIT_M;
          end
        end
      end
      ST_FIN: begin
        if (res_ready) begin
          st_nxt = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      last_r <= '0;
      wr_r   <= '0;
      rd_r   <= '0;
    end else begin
      st_r   <= st_nxt;
      last_r <= last_nxt;
      wr_r   <= wr_nxt;
      rd_r   <= rd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      act_r  <= in_data.action;
      time_r <= in_data.edge_time_us;
    end
    gap_r   <= gap_nxt;
    rptr_r  <= rptr_nxt;
    bit_r   <= bit_nxt;
    hm_ok_r <= hm_ok_nxt;
    m_ok_r  <= m_ok_nxt;
    code_r  <= code_nxt;
    found_r <= found_nxt;
    rep_r   <= rep_nxt;
  end

endmodule

`default_nettype wire

// ===== hdl/nec_ir_edge_decoder.sv =====
// Top level of the NEC IR edge decoder: config register, ring RAM, sequencer, output stage.
`default_nettype none

// NEC IR edge decoder. Each input transfer carries one action: an edge with its
// microsecond timestamp, a decode attempt, a resume (drop everything pending) or
// an arm (empty the ring and restart the edge clock at the given time). Edges store
// the gap to the previous edge, saturated to 16 bits, in a 128-entry duration ring
// held in a synchronous RAM; gaps above idle_gap_limit are dropped as idle and a
// full ring loses its oldest duration. A decode walks the ring from the oldest
// entry, one RAM read per cycle, and returns a data frame, a repeat frame or
// nothing. Every input transfer yields exactly one output transfer carrying the
// ring fill level after the action. A full 32-bit data frame is walked with 66
// sequential reads through the single ring read port (a bad bit ends the walk
// early). The next input is accepted once the result has moved into the output
// register and the sequencer is back in idle. One action is in flight at a
// time; the output register lets the next input be accepted while the previous
// result waits for out_ready. The ring RAM contents are not cleared at reset;
// only entries written since are ever read. The config port is always ready and
// is to be written only while the block is idle.

module nec_ir_edge_decoder
  import nir_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire in_item_t           in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output out_item_t               out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [LIMIT_W-1:0] cfg_data
);

  logic [LIMIT_W-1:0] idle_gap_limit_r;
  logic               out_valid_r;
  out_item_t          out_data_r;

  logic               res_valid;
  logic               res_ready;
  out_item_t          res_data;
  ram_req_t           ram_req;
  logic [DUR_W-1:0]   ram_rdata;

  // config register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_gap_limit_r <= IDLE_GAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      idle_gap_limit_r <= cfg_data;
    end
  end

  nir_ring_ram #(
    .DEPTH (RING_DEPTH),
    .WIDTH (DUR_W),
    .AW    (IDX_W)
  ) u_ring (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  nir_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .idle_gap_limit (idle_gap_limit_r),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .res_data       (res_data),
    .ram_req        (ram_req),
    .ram_rdata      (ram_rdata)
  );

  // output register: take a new result when empty or draining this cycle
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== hdl/nir_checker.sv =====
// Port-level checker for the NEC IR edge decoder and its bind to the top level.
`default_nettype none

module nir_checker
  import nir_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output transfer changed while stalled");

  a_no_out_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_repeat_needs_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_repeat |-> out_data.frame_found
                                        && (out_data.code_value == 32'd0))
    else $error("repeat flag without frame or with nonzero code");

  a_code_needs_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.frame_found |-> out_data.code_value == 32'd0)
    else $error("code value without a frame");

  a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> {1'b0, out_data.pending_count} <= 9'(RING_DEPTH - 1))
    else $error("pending count beyond ring capacity");

endmodule

bind nec_ir_edge_decoder nir_checker u_nir_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for the NEC IR edge decoder: random handshakes, frame traffic, scoreboard.
module testbench;
  import nir_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;  // cycles with no transfer at all
  localparam int unsigned SETTLE_CYCLES  = 100;   // longer than one full data-frame decode
  localparam int unsigned MAX_REPORTS    = 10;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  in_item_t            in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [LIMIT_W-1:0]  cfg_data = '0;

  nec_ir_edge_decoder uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Decoder shadow state, advanced once per accepted input transfer.
  logic [31:0]        last_edge_sh;
  logic [DUR_W-1:0]   ring_sh [RING_DEPTH];
  logic [IDX_W-1:0]   wr_sh;
  logic [IDX_W-1:0]   rd_sh;
  logic [LIMIT_W-1:0] idle_limit_sh;

  in_item_t    pending_items [$];
  out_item_t   nec_result_q [$];
  out_item_t   result_head;
  int unsigned items_queued = 0;
  int unsigned items_accepted = 0;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int          in_hold = 0;
  int          out_stall = 0;
  bit          calm = 1'b0;      // no idling on either side
  logic [31:0] gen_time;         // timestamp of the last generated edge

  // Works out the result of one input item and queues it.
  task automatic predict_nec_result(input in_item_t item);
    out_item_t        res;
    logic [31:0]      gap;
    logic [IDX_W-1:0] fill;
    logic [DUR_W-1:0] hm, hs, mk, sp;
    logic             bits_ok;
    res = '0;
    case (item.action)
      ACT_EDGE: begin
        gap = item.edge_time_us - last_edge_sh;
        last_edge_sh = item.edge_time_us;
        if (gap <= idle_limit_sh) begin
          if (gap > DUR_SAT) gap = 32'(DUR_SAT);
          // full ring: oldest duration goes first
          if (IDX_W'(wr_sh + 1) == rd_sh) rd_sh = rd_sh + 1'b1;
          ring_sh[wr_sh] = gap[DUR_W-1:0];
          wr_sh = wr_sh + 1'b1;
        end
      end
      ACT_DECODE: begin
        fill = wr_sh - rd_sh;
        if (fill >= HDR_MIN_AVAIL) begin
          hm = ring_sh[rd_sh];
          hs = ring_sh[IDX_W'(rd_sh + 1)];
          if (hm < HDR_MARK_MIN || hm > HDR_MARK_MAX ||
              hs < HDR_SPACE_MIN || hs > HDR_SPACE_MAX) begin
            rd_sh = rd_sh + 1'b1;
          end else if (hs <= HDR_SPACE_DATA) begin
            rd_sh = rd_sh + REPEAT_LEN;
            res.frame_found = 1'b1;
            res.is_repeat = 1'b1;
          end else if (fill >= DATA_FRAME_LEN) begin
            bits_ok = 1'b1;
            for (int i = 0; i < 32 && bits_ok; i++) begin
              mk = ring_sh[IDX_W'(rd_sh + 2 + 2 * i)];
              sp = ring_sh[IDX_W'(rd_sh + 3 + 2 * i)];
              if (mk < BIT_MARK_MIN || mk > BIT_MARK_MAX ||
                  sp < BIT_SPACE_MIN || sp > BIT_SPACE_MAX) begin
                bits_ok = 1'b0;
              end else if (sp > BIT_ONE_SPACE) begin
                res.code_value[i] = 1'b1;
              end
            end
            if (bits_ok) begin
              rd_sh = rd_sh + DATA_FRAME_LEN;
              res.frame_found = 1'b1;
            end else begin
              // bad bit: only the header mark is dropped
              rd_sh = rd_sh + 1'b1;
              res.code_value = '0;
            end
          end
        end
      end
      ACT_RESUME: begin
        rd_sh = wr_sh;
      end
      ACT_ARM: begin
        wr_sh = '0;
        rd_sh = '0;
        last_edge_sh = item.edge_time_us;
      end
    endcase
    res.pending_count = 8'(IDX_W'(wr_sh - rd_sh));
    nec_result_q.push_back(res);
  endtask

  // Input driver: one transfer per handshake, random hold-off after some (none when calm).
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_hold = 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_nec_result(in_data);
        items_accepted++;
        if (!calm && $urandom_range(0, 5) == 0) in_hold = $urandom_range(1, 7);
      end
      if (!in_valid || in_ready) begin
        if (in_hold > 0) begin
          in_hold--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and scoreboard; out_ready drops in random bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (nec_result_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result transfer: found=%0d rep=%0d code=%h pend=%0d",
                     out_data.frame_found, out_data.is_repeat, out_data.code_value,
                     out_data.pending_count);
        end else begin
          result_head = nec_result_q.pop_front();
          if (out_data.frame_found !== result_head.frame_found ||
              out_data.is_repeat !== result_head.is_repeat ||
              out_data.code_value !== result_head.code_value ||
              out_data.pending_count !== result_head.pending_count) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display({"mismatch: got found=%0d rep=%0d code=%h pend=%0d, ",
                        "want found=%0d rep=%0d code=%h pend=%0d"},
                       out_data.frame_found, out_data.is_repeat, out_data.code_value,
                       out_data.pending_count, result_head.frame_found,
                       result_head.is_repeat, result_head.code_value,
                       result_head.pending_count);
          end
        end
      end
      if (out_stall > 0) out_stall--;
      else if (!calm && $urandom_range(0, 7) == 0) out_stall = $urandom_range(1, 7);
      out_ready <= (out_stall == 0);
    end
  end

  // Watchdog: a stretch with no transfer on any channel ends the run.
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready) ||
                 (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic queue_item(input logic [1:0] act, input logic [31:0] t);
    in_item_t item;
    item.action = act;
    item.edge_time_us = t;
    pending_items.push_back(item);
    items_queued++;
  endtask

  task automatic queue_edge_after(input int unsigned dur);
    gen_time = gen_time + dur;
    queue_item(ACT_EDGE, gen_time);
  endtask

  task automatic queue_decodes(input int unsigned n);
    repeat (n) queue_item(ACT_DECODE, $urandom());
  endtask

  // Value inside a timing window, biased toward its bounds.
  function automatic int unsigned pick_in(input int unsigned lo, input int unsigned hi);
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r == 0) return lo;
    if (r == 1) return hi;
    return $urandom_range(lo, hi);
  endfunction

  // One NEC frame as edges, led by an idle-ish gap. spoil pushes one
  // duration just outside its window.
  task automatic queue_nec_frame(input bit repeat_frame, input bit spoil);
    int unsigned d [66];
    int unsigned n, pos, lo, hi;
    n = repeat_frame ? 3 : 66;
    d[0] = pick_in(HDR_MARK_MIN, HDR_MARK_MAX);
    if (repeat_frame) begin
      d[1] = pick_in(HDR_SPACE_MIN, HDR_SPACE_DATA);
      d[2] = pick_in(BIT_MARK_MIN, BIT_MARK_MAX);
    end else begin
      d[1] = pick_in(HDR_SPACE_DATA + 1, HDR_SPACE_MAX);
      for (int i = 0; i < 32; i++) begin
        d[2 + 2 * i] = pick_in(BIT_MARK_MIN, BIT_MARK_MAX);
        d[3 + 2 * i] = $urandom_range(0, 1) ? pick_in(BIT_ONE_SPACE + 1, BIT_SPACE_MAX)
                                            : pick_in(BIT_SPACE_MIN, BIT_ONE_SPACE);
      end
    end
    if (spoil) begin
      pos = $urandom_range(0, n - 1);
      if (pos == 0) begin
        lo = HDR_MARK_MIN;
        hi = HDR_MARK_MAX;
      end else if (pos == 1) begin
        lo = HDR_SPACE_MIN;
        hi = HDR_SPACE_MAX;
      end else if (pos % 2 == 0) begin
        lo = BIT_MARK_MIN;
        hi = BIT_MARK_MAX;
      end else begin
        lo = BIT_SPACE_MIN;
        hi = BIT_SPACE_MAX;
      end
      d[pos] = $urandom_range(0, 1) ? lo - 1 : hi + 1;
    end
    if ($urandom_range(0, 3) == 0) queue_edge_after($urandom_range(0, 20000));
    else queue_edge_after($urandom_range(20000, 150000));
    for (int i = 0; i < n; i++) queue_edge_after(d[i]);
  endtask

  // Mostly well-formed frames with random content; some noise, flushes, arms.
  task automatic queue_random_traffic(input int unsigned count);
    int unsigned start, r, k;
    start = items_queued;
    while (items_queued - start < count) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        queue_nec_frame(1'b0, $urandom_range(0, 9) == 0);
        queue_decodes($urandom_range(1, 3));
      end else if (r < 55) begin
        queue_nec_frame(1'b1, $urandom_range(0, 9) == 0);
        queue_decodes($urandom_range(1, 2));
      end else if (r < 63) begin
        // no decode: back-to-back frames overrun the ring
        queue_nec_frame($urandom_range(0, 1), 1'b0);
      end else if (r < 80) begin
        k = $urandom_range(1, 10);
        repeat (k) begin
          case ($urandom_range(0, 4))
            0: queue_edge_after(0);
            1: queue_edge_after($urandom_range(1, 1500));
            2: queue_edge_after($urandom_range(0, 70000));
            3: queue_edge_after($urandom());
            default: queue_edge_after($urandom_range(1000000, 1100000));
          endcase
        end
        queue_decodes(1);
      end else if (r < 88) begin
        queue_decodes(1);
      end else if (r < 94) begin
        queue_item(ACT_RESUME, $urandom());
      end else begin
        gen_time = $urandom();
        queue_item(ACT_ARM, gen_time);
      end
    end
  endtask

  // Wait until every queued item has its result back, then let the block settle.
  task automatic drain();
    while (items_accepted != items_queued || nec_result_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write; only called while the block is idle.
  task automatic write_idle_limit(input logic [LIMIT_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    idle_limit_sh = v;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    last_edge_sh = '0;
    wr_sh = '0;
    rd_sh = '0;
    idle_limit_sh = IDLE_GAP_RESET;
    for (int i = 0; i < RING_DEPTH; i++) ring_sh[i] = '0;
    gen_time = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset limit of 50000 us.
    queue_item(ACT_DECODE, 32'hFFFF_FFFF);   // empty ring
    queue_edge_after(50000);                 // gap equal to the limit is kept
    queue_edge_after(50001);                 // idle gap, dropped
    queue_edge_after(0);                     // zero-length duration
    queue_item(ACT_RESUME, 32'h0);
    queue_item(ACT_ARM, 32'hFFFF_FFFF);
    gen_time = 32'hFFFF_FFFF;
    queue_edge_after(1);                     // timestamp wraps to zero
    queue_item(ACT_RESUME, $urandom());
    queue_edge_after(9000);                  // repeat frame
    queue_edge_after(2250);
    queue_edge_after(560);
    queue_decodes(1);
    queue_edge_after(3000);                  // bad header, then too few left
    queue_edge_after(2000);
    queue_edge_after(500);
    queue_decodes(2);
    queue_item(ACT_RESUME, $urandom());
    queue_edge_after(9000);                  // data header with too few durations
    queue_edge_after(4500);
    queue_edge_after(560);
    queue_decodes(1);
    queue_item(ACT_ARM, 32'h0);
    gen_time = '0;
    drain();

    // Widest limit: saturation and gaps past the limit.
    write_idle_limit(LIMIT_W'(1000000));
    gen_time = $urandom();
    queue_item(ACT_ARM, gen_time);
    queue_edge_after(70000);
    queue_edge_after(1000001);
    queue_edge_after(1000000);
    queue_decodes(1);
    queue_random_traffic(90);
    drain();

    // Zero limit: only same-time edges are stored.
    write_idle_limit(LIMIT_W'(0));
    queue_random_traffic(25);
    drain();

    write_idle_limit(LIMIT_W'($urandom_range(1, 999999)));
    queue_random_traffic(75);
    drain();

    // Reset value written back; last stretch runs with no idling.
    write_idle_limit(IDLE_GAP_RESET);
    calm = 1'b1;
    queue_random_traffic(85);
    drain();

    if (mismatches == 0 && nec_result_q.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ===== nec_ir_edge_decoder.f =====
hdl/nir_pkg.sv
hdl/nir_ring_ram.sv
hdl/nir_ctrl.sv
hdl/nec_ir_edge_decoder.sv
hdl/nir_checker.sv
bench/testbench.sv
